// ===== rtl/sydd_pkg.sv =====
// Shared types, field widths and calendar tables for the same-year day difference core.
package sydd_pkg;

   // Field widths
   localparam int DayW      = 7;
   localparam int MonthW    = 7;
   localparam int YearW     = 14;
   localparam int CountW    = 9;
   localparam int ReqDataW  = 64;
   localparam int RspDataW  = 16;

   // Result status codes, in check order
   typedef enum logic [2:0] {
      StatusOk        = 3'd0,
      StatusYearDiff  = 3'd1,
      StatusBadMonth  = 3'd2,
      StatusBadDay    = 3'd3,
      StatusOrder     = 3'd4
   } status_type;

   // One request beat, unpacked
   typedef struct packed {
      logic [DayW-1:0]   start_day;
      logic [MonthW-1:0] start_month;
      logic [YearW-1:0]  start_year;
      logic [DayW-1:0]   end_day;
      logic [MonthW-1:0] end_month;
      logic [YearW-1:0]  end_year;
      logic              include_end;
   } req_type;

   // One response beat, unpacked
   typedef struct packed {
      logic [CountW-1:0] day_count;
      status_type        status;
   } rsp_type;

   // Divisibility by 25: multiply by the inverse of 25 mod 2^14, then a
   // multiple of 25 lands at or below floor((2^14 - 1) / 25).
   localparam logic [YearW-1:0] Inv25 = 14'd7209;
   localparam logic [YearW-1:0] Lim25 = 14'd655;

   // Gregorian 4/100/400 leap rule
   function automatic logic is_leap(input logic [YearW-1:0] year);
      logic [2*YearW-1:0] prod;
      logic               div4;
      logic               div16;
      logic               div25;
      prod  = year * Inv25;
      div25 = (prod[YearW-1:0] <= Lim25);
      div4  = (year[1:0] == 2'd0);
      div16 = (year[3:0] == 4'd0);
      return div4 && (!div25 || div16);
   endfunction

   // Days in a month (month 1..12), zero for anything else
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // Day of year of the first of a month (month 1..12)
   function automatic logic [8:0] first_doy(input logic [3:0] month, input logic leap);
      logic [8:0] doy;
      case (month)
         4'd1:    doy = 9'd1;
         4'd2:    doy = 9'd32;
         4'd3:    doy = 9'd60;
         4'd4:    doy = 9'd91;
         4'd5:    doy = 9'd121;
         4'd6:    doy = 9'd152;
         4'd7:    doy = 9'd182;
         4'd8:    doy = 9'd213;
         4'd9:    doy = 9'd244;
         4'd10:   doy = 9'd274;
         4'd11:   doy = 9'd305;
         4'd12:   doy = 9'd335;
         default: doy = 9'd0;
      endcase
      // leap day shifts every month from March on
      if (leap && (month >= 4'd3)) begin
         doy = doy + 9'd1;
      end
      return doy;
   endfunction

endpackage

// ===== rtl/sydd_date_check.sv =====
// Date validation and day-of-year difference for one registered request.
module sydd_date_check (
   input  sydd_pkg::req_type req,
   output sydd_pkg::rsp_type rsp
);
   import sydd_pkg::*;

   logic       leap;
   logic       sm_ok;
   logic       em_ok;
   logic [3:0] sm;
   logic [3:0] em;
   logic [4:0] s_len;
   logic [4:0] e_len;
   logic       sd_ok;
   logic       ed_ok;
   logic       after;
   logic [9:0] s_pos;
   logic [9:0] e_pos;
   logic [9:0] diff;

   // Month range and table lookups
   assign leap  = is_leap(req.start_year);
   assign sm_ok = (req.start_month >= 7'd1) && (req.start_month <= 7'd12);
   assign em_ok = (req.end_month >= 7'd1) && (req.end_month <= 7'd12);
   assign sm    = req.start_month[3:0];
   assign em    = req.end_month[3:0];
   assign s_len = month_len(sm, leap);
   assign e_len = month_len(em, leap);

   // Day range and ordering
   assign sd_ok = (req.start_day != 7'd0) && (req.start_day <= {2'b00, s_len});
   assign ed_ok = (req.end_day != 7'd0) && (req.end_day <= {2'b00, e_len});
   assign after = (sm > em) || ((sm == em) && (req.start_day > req.end_day));

   // Day-of-year positions; the common offset of one cancels in the difference
   assign s_pos = {1'b0, first_doy(sm, leap)} + {3'b000, req.start_day};
   assign e_pos = {1'b0, first_doy(em, leap)} + {3'b000, req.end_day};
   assign diff  = e_pos - s_pos + {9'd0, req.include_end};

   // First failing check wins
   always_comb begin
      rsp.day_count = '0;
      if (req.start_year != req.end_year) begin
         rsp.status = StatusYearDiff;
      end else if (!sm_ok || !em_ok) begin
         rsp.status = StatusBadMonth;
      end else if (!sd_ok || !ed_ok) begin
         rsp.status = StatusBadDay;
      end else if (after) begin
         rsp.status = StatusOrder;
      end else begin
         rsp.status    = StatusOk;
         rsp.day_count = diff[CountW-1:0];
      end
   end

endmodule

// ===== rtl/same_year_day_difference_core.sv =====
// Top level of the same-year day difference core: input stage, check logic, output stage.
//
// Usage
//   req_ channel: one beat carries a start date, an end date (day, month,
//   year each) and an include-end flag. rsp_ channel: one beat per request
//   carries the day count and a status code; the count is zero unless the
//   status is ok. Beats leave in the order they arrive.
// Flow and throughput
//   A request beat is registered in the input stage, checked by single-pass
//   logic (leap test, month tables, one subtraction) and the result
//   registered in the output stage, where it is offered to the receiver.
//   One beat is taken every cycle while the receiver keeps rsp_tready high.
// Reset
//   reset clears both stage valid flags; nothing is in flight afterwards
//   and req_tready is high in the first cycle after reset.
// Stalls
//   With rsp_tready low the output beat is held unchanged. The input stage
//   still takes one more beat while the output stage is full, then
//   req_tready drops until the receiver takes the waiting response.
module same_year_day_difference_core (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: start_day[6:0], start_month[13:7], start_year[27:14],
   //            end_day[34:28], end_month[41:35], end_year[55:42],
   //            include_end[56], zero[63:57]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sydd_pkg::ReqDataW-1:0] req_tdata,
   // rsp_tdata: day_count[8:0], status[11:9], zero[15:12]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sydd_pkg::RspDataW-1:0] rsp_tdata
);
   import sydd_pkg::*;

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_req_ff;
   req_type req_beat;
   logic    s2_valid_ff;
   logic    s2_valid_in;
   rsp_type s2_rsp_ff;
   rsp_type rsp_calc;
   logic    s1_load;
   logic    s2_load;
   logic    s2_free;

   // Unpack the request beat
   assign req_beat.start_day   = req_tdata[6:0];
   assign req_beat.start_month = req_tdata[13:7];
   assign req_beat.start_year  = req_tdata[27:14];
   assign req_beat.end_day     = req_tdata[34:28];
   assign req_beat.end_month   = req_tdata[41:35];
   assign req_beat.end_year    = req_tdata[55:42];
   assign req_beat.include_end = req_tdata[56];

   // Handshake flow: each stage moves when the one after it has room
   assign s2_free     = !s2_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || s2_free;
   assign s1_load     = req_tvalid && req_tready;
   assign s2_load     = s1_valid_ff && s2_free;
   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_free);
   assign s2_valid_in = s2_load || (s2_valid_ff && !rsp_tready);

   // Stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_req_ff <= req_beat;
      end
      if (s2_load) begin
         s2_rsp_ff <= rsp_calc;
      end
   end

   sydd_date_check u_date_check (
      .req (s1_req_ff),
      .rsp (rsp_calc)
   );

   // Pack the response beat
   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {4'b0000, s2_rsp_ff.status, s2_rsp_ff.day_count};

endmodule

// ===== rtl/sydd_checker.sv =====
// Port-level checks for the same-year day difference core, bound to the top level.
module sydd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [sydd_pkg::ReqDataW-1:0] req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [sydd_pkg::RspDataW-1:0] rsp_tdata
);
   import sydd_pkg::*;

   logic req_seen;

   // request payload is looked at whenever req_tvalid is high, moved or not
   assign req_seen = req_tvalid && (req_tdata[63:57] == 7'd0);

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // Any failing check forces a zero count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:9] != StatusOk) |-> rsp_tdata[8:0] == 9'd0)
      else $error("non-zero count with error status");

   // A good result never exceeds 366, a full leap year with the end day counted
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:9] == StatusOk) |-> rsp_tdata[8:0] <= 9'd366)
      else $error("day count out of range");

   // Back-pressure only comes from a full output stage
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready || (req_seen && !req_tready) |-> rsp_tvalid)
      else $error("request stalled with empty output stage");

endmodule

bind same_year_day_difference_core sydd_checker u_sydd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the same-year day difference core.
`timescale 1ns / 100ps

module tb;
   import sydd_pkg::*;

   localparam int ResetCycles = 12;
   localparam int QuietLimit  = 1000;   // cycles with work pending but no beat moving
   localparam int SettleTime  = 8;      // wait after draining, before the verdict
   localparam int HoldoffLen  = 80;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   req_type dates_todo [$];   // date pairs still to be offered
   rsp_type span_due   [$];   // predicted responses, oldest first

   logic req_taken    = 1'b0;
   int   beats_in     = 0;
   int   beats_out    = 0;
   int   mismatches   = 0;
   int   quiet_cycles = 0;

   // sender burst state
   int burst_left = 0;
   int gap_left   = 0;

   // receiver stall state
   int rx_mode       = 0;
   int rx_mode_left  = 0;
   int hold_left     = 0;
   int holdoffs_used = 0;
   int rx_tick       = 0;

   same_year_day_difference_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Calendar arithmetic
   // ---------------------------------------------------------------
   function automatic logic leap_year(logic [YearW-1:0] y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_in_month(logic [MonthW-1:0] m, logic leap);
      case (m)
         7'd2:                      return leap ? 29 : 28;
         7'd4, 7'd6, 7'd9, 7'd11:   return 30;
         7'd1, 7'd3, 7'd5, 7'd7,
         7'd8, 7'd10, 7'd12:        return 31;
         default:                   return 0;
      endcase
   endfunction

   // day of year counted by summing the lengths of the earlier months
   function automatic int day_of_year(logic [MonthW-1:0] m, logic [DayW-1:0] d, logic leap);
      int n;
      n = int'(d);
      for (int k = 1; k < m; k++) n += days_in_month(MonthW'(k), leap);
      return n;
   endfunction

   // expected response for one date pair; first failing check wins
   function automatic rsp_type span_of_dates(req_type d);
      rsp_type r;
      logic    leap;
      int      first;
      int      last;
      r.day_count = '0;
      r.status    = StatusOk;
      leap        = leap_year(d.start_year);
      if (d.start_year != d.end_year) begin
         r.status = StatusYearDiff;
      end else if (d.start_month < 1 || d.start_month > 12 ||
                   d.end_month < 1 || d.end_month > 12) begin
         r.status = StatusBadMonth;
      end else if (d.start_day == 0 || d.start_day > days_in_month(d.start_month, leap) ||
                   d.end_day == 0 || d.end_day > days_in_month(d.end_month, leap)) begin
         r.status = StatusBadDay;
      end else if (d.start_month > d.end_month ||
                   (d.start_month == d.end_month && d.start_day > d.end_day)) begin
         r.status = StatusOrder;
      end else begin
         first       = day_of_year(d.start_month, d.start_day, leap);
         last        = day_of_year(d.end_month, d.end_day, leap);
         r.day_count = CountW'(last - first + d.include_end);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Beat packing: first field in the lowest bits
   // ---------------------------------------------------------------
   function automatic logic [ReqDataW-1:0] pack_dates(req_type d);
      return {7'd0, d.include_end, d.end_year, d.end_month, d.end_day,
              d.start_year, d.start_month, d.start_day};
   endfunction

   function automatic req_type unpack_dates(logic [ReqDataW-1:0] v);
      req_type d;
      d.start_day   = v[6:0];
      d.start_month = v[13:7];
      d.start_year  = v[27:14];
      d.end_day     = v[34:28];
      d.end_month   = v[41:35];
      d.end_year    = v[55:42];
      d.include_end = v[56];
      return d;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic add_dates(int sd, int sm, int sy, int ed, int em, int ey, int inc);
      req_type d;
      d.start_day   = DayW'(sd);
      d.start_month = MonthW'(sm);
      d.start_year  = YearW'(sy);
      d.end_day     = DayW'(ed);
      d.end_month   = MonthW'(em);
      d.end_year    = YearW'(ey);
      d.include_end = inc[0];
      dates_todo.push_back(d);
   endtask

   // mostly valid ordered pairs in one year; the rest broken or pure noise
   task automatic add_random_dates();
      req_type          d;
      logic             leap;
      logic [YearW-1:0] yr;
      logic [YearW-1:0] ty;
      logic [MonthW-1:0] tm;
      logic [DayW-1:0]  td;
      logic             on_end;
      int               kind;
      case ($urandom_range(0, 4))
         0:       yr = YearW'($urandom_range(0, 16383));
         1:       yr = YearW'($urandom_range(0, 40) * 400);
         2:       yr = YearW'($urandom_range(0, 163) * 100);
         3:       yr = YearW'($urandom_range(0, 4095) * 4);
         default: yr = YearW'($urandom_range(1900, 2100));
      endcase
      leap          = leap_year(yr);
      d.start_year  = yr;
      d.end_year    = yr;
      d.start_month = MonthW'($urandom_range(1, 12));
      d.end_month   = MonthW'($urandom_range(d.start_month, 12));
      d.start_day   = DayW'($urandom_range(1, days_in_month(d.start_month, leap)));
      if (d.end_month == d.start_month)
         d.end_day = DayW'($urandom_range(d.start_day, days_in_month(d.end_month, leap)));
      else
         d.end_day = DayW'($urandom_range(1, days_in_month(d.end_month, leap)));
      d.include_end = 1'($urandom_range(0, 1));
      on_end        = 1'($urandom_range(0, 1));
      kind          = $urandom_range(0, 99);
      if (kind >= 70 && kind < 76) begin
         // reversed pair
         tm            = d.start_month;
         d.start_month = d.end_month;
         d.end_month   = tm;
         td            = d.start_day;
         d.start_day   = d.end_day;
         d.end_day     = td;
      end else if (kind >= 76 && kind < 82) begin
         // day zero or past the month's end
         if (on_end) begin
            td = ($urandom_range(0, 2) == 0) ? 7'd0 :
                 DayW'($urandom_range(days_in_month(d.end_month, leap) + 1, 127));
            d.end_day = td;
         end else begin
            td = ($urandom_range(0, 2) == 0) ? 7'd0 :
                 DayW'($urandom_range(days_in_month(d.start_month, leap) + 1, 127));
            d.start_day = td;
         end
      end else if (kind >= 82 && kind < 87) begin
         tm = ($urandom_range(0, 2) == 0) ? 7'd0 : MonthW'($urandom_range(13, 127));
         if (on_end) d.end_month = tm;
         else        d.start_month = tm;
      end else if (kind >= 87 && kind < 92) begin
         ty = YearW'($urandom_range(0, 16383));
         if (ty == yr) ty = ~yr;
         if (on_end) d.end_year = ty;
         else        d.start_year = ty;
      end else if (kind >= 92) begin
         d = unpack_dates({$urandom, $urandom});
      end
      dates_todo.push_back(d);
   endtask

   // hold further stimulus until every offered pair has its response back
   task automatic wait_drained();
      do @(posedge clock);
      while (dates_todo.size() != 0 || req_tvalid || span_due.size() != 0);
   endtask

   task automatic report_mismatch(string msg);
      $display("[%0t] response %0d: %s", $realtime, beats_out, msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------
   // Sender: bursts of random length with random gaps
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_taken)) begin
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (dates_todo.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pack_dates(dates_todo.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: stall pattern changes at random intervals, plus two
   // long hold-offs while the sender keeps offering
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         rx_tick <= rx_tick + 1;
         if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 4);
            rx_mode_left <= $urandom_range(20, 80);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (holdoffs_used < 2 && beats_in >= 100 + 200 * holdoffs_used) begin
            hold_left     <= HoldoffLen - 1;
            holdoffs_used <= holdoffs_used + 1;
            rsp_tready    <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (rx_tick[1:0] != 2'd3);
               3:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (rx_tick[2] == 1'b0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predict on request beats, compare on response beats
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.day_count = rsp_tdata[8:0];
            got.status    = status_type'(rsp_tdata[11:9]);
            if (span_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat count=%0d status=%0d",
                                         got.day_count, got.status));
            end else begin
               want = span_due.pop_front();
               if (got.day_count !== want.day_count)
                  report_mismatch($sformatf("day_count %0d, expected %0d",
                                            got.day_count, want.day_count));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
            end
            beats_out <= beats_out + 1;
         end
         if (req_tvalid && req_tready) begin
            span_due.push_back(span_of_dates(unpack_dates(req_tdata)));
            beats_in <= beats_in + 1;
         end
      end
   end

   // watchdog: only counts while something is still outstanding
   always @(posedge clock) begin
      if (!reset && (dates_todo.size() != 0 || req_tvalid || span_due.size() != 0) &&
          !(req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         quiet_cycles <= 0;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("watchdog: no beat moved for %0d cycles", QuietLimit);
         $display("** same_year_day_difference_core: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      // directed pairs, queued before reset is released
      add_dates( 1,   1, 2024,  1,   1, 2023, 0);   // years differ
      add_dates( 1,   1, 16383, 31, 12, 16383, 1);  // largest year field, whole year
      add_dates(29,   2,    0,  1,   3,    0, 0);   // year zero is a leap year
      add_dates( 1,   0, 2020,  1,   1, 2020, 0);   // start month zero
      add_dates( 1,   1, 2020,  1,  13, 2020, 0);   // end month thirteen
      add_dates( 1, 127, 2020,  1, 127, 2020, 1);   // largest month field
      add_dates( 0,   1, 2020,  5,   1, 2020, 0);   // start day zero
      add_dates( 1,   1, 2020, 127,  1, 2020, 0);   // largest day field
      add_dates(29,   2, 1900,  1,   3, 1900, 0);   // century, not a leap year
      add_dates(29,   2, 2000,  1,   3, 2000, 1);   // divisible by 400
      add_dates(28,   2, 2024, 29,   2, 2024, 0);   // ordinary leap year
      add_dates( 1,   2, 2023, 29,   2, 2023, 0);   // leap day in a common year
      add_dates( 6,   5, 2021,  3,   1, 2021, 0);   // later start month
      add_dates(15,   3, 2021, 14,   3, 2021, 1);   // same month, later start day
      add_dates(10,   7, 2021, 10,   7, 2021, 0);   // same date, count zero
      add_dates(10,   7, 2021, 10,   7, 2021, 1);   // same date counted
      add_dates( 1,   1, 2024, 31,  12, 2024, 1);   // largest count
      add_dates( 1,   1, 2023, 31,  12, 2023, 0);   // whole common year
      add_dates( 1,   0, 2023,  1,   1, 2022, 0);   // year check comes first
      add_dates( 0,  13, 2023,  1,   1, 2023, 0);   // month check before day check
      add_dates(40,   6, 2023,  1,   1, 2023, 0);   // day check before order check
      add_dates(31,   4, 2023,  1,   5, 2023, 0);   // April has thirty days
      add_dates( 1,   4, 2023, 31,   4, 2023, 0);
      add_dates(29,   2, 10000, 31,  12, 10000, 1); // beyond four digits, still leap rule
      add_dates(29,   2, 16300, 1,   3, 16300, 0);  // beyond four digits, century

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait_drained();
      repeat (200) add_random_dates();
      // sender pauses here until every response is back
      wait_drained();
      repeat (250) add_random_dates();
      wait_drained();
      repeat (SettleTime) @(posedge clock);

      if (mismatches == 0) begin
         $display("** same_year_day_difference_core: PASSED **");
      end else begin
         $display("** same_year_day_difference_core: FAILED **");
      end
      $finish;
   end

endmodule
